FILE: src/pgw_pkg.sv
package pgw_pkg;

  // Table memory depth in 64-bit words; must be a power of two (512 .. 1M).
  localparam int unsigned MemWords = 4096;
  localparam int unsigned AddrW    = $clog2(MemWords);

  localparam int unsigned EntryW  = 64;
  localparam int unsigned FrameW  = 40;
  localparam int unsigned VaW     = 48;
  localparam int unsigned PaW     = 52;
  localparam int unsigned WidxW   = 12;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned OffW    = 12;
  localparam int unsigned LevelW  = 2;

  // frame field of an entry: bits 51..12
  localparam int unsigned FrameLsb = 12;
  localparam int unsigned FrameMsb = FrameLsb + FrameW - 1;

  localparam logic [LevelW-1:0] LastLevel = LevelW'(3);

  // item command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdWalk  = 1'b1;

  // walk status codes
  localparam logic [StatusW-1:0] StMapped   = StatusW'(0);
  localparam logic [StatusW-1:0] StNoRoot   = StatusW'(1);
  localparam logic [StatusW-1:0] StAbsentL4 = StatusW'(2);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WALK  = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    RES_WRITE,
    RES_NOROOT,
    RES_ABSENT,
    RES_MAPPED
  } res_e;

  typedef struct packed {
    logic              accept;
    logic              clr_we;
    logic              item_we;
    logic              first_rd;
    logic              step_rd;
    logic [LevelW-1:0] rd_level;
    logic              load;
    res_e              res;
    logic [LevelW-1:0] level;
  } dp_cmd_t;

  typedef struct packed {
    logic is_walk;
    logic root_zero;
    logic present;
    logic clr_last;
  } dp_sts_t;

  // nine-bit table index of a virtual address for a given level (0 = top)
  function automatic logic [IdxW-1:0] level_index(input logic [VaW-1:0] va,
                                                  input logic [LevelW-1:0] level);
    logic [IdxW-1:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: src/pgw_req_if.sv
interface pgw_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [pgw_pkg::VaW-1:0]      virtual_address;
  logic [pgw_pkg::WidxW-1:0]    word_index;
  logic [pgw_pkg::EntryW-1:0]   entry_data;

  modport source (output valid, cmd, virtual_address, word_index, entry_data,
                  input ready);
  modport sink   (input valid, cmd, virtual_address, word_index, entry_data,
                  output ready);
endinterface

FILE: src/pgw_rsp_if.sv
interface pgw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pgw_pkg::PaW-1:0]       physical_address;
  logic [pgw_pkg::EntryW-1:0]    leaf_entry;
  logic [pgw_pkg::StatusW-1:0]   walk_status;

  modport source (output valid, physical_address, leaf_entry, walk_status,
                  input ready);
  modport sink   (input valid, physical_address, leaf_entry, walk_status,
                  output ready);
endinterface

FILE: src/pgw_ram.sv
module pgw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pgw_dp.sv
module pgw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgw_pkg::FrameW-1:0]    cfg_wdata_i,
  input  pgw_pkg::dp_cmd_t              cmd_i,
  output pgw_pkg::dp_sts_t              sts_o,
  input  logic                          in_cmd_i,
  input  logic [pgw_pkg::VaW-1:0]       in_va_i,
  input  logic [pgw_pkg::WidxW-1:0]     in_widx_i,
  input  logic [pgw_pkg::EntryW-1:0]    in_data_i,
  output logic [pgw_pkg::PaW-1:0]       pa_o,
  output logic [pgw_pkg::EntryW-1:0]    leaf_o,
  output logic [pgw_pkg::StatusW-1:0]   status_o
);

  logic [pgw_pkg::FrameW-1:0]  root_q;
  logic [pgw_pkg::VaW-1:0]     va_q;
  logic [pgw_pkg::AddrW-1:0]   clr_q, clr_d;
  logic [pgw_pkg::PaW-1:0]     pa_q, pa_d;
  logic [pgw_pkg::EntryW-1:0]  leaf_q, leaf_d;
  logic [pgw_pkg::StatusW-1:0] st_q, st_d;

  logic                                       ram_we, ram_re;
  logic [pgw_pkg::AddrW-1:0]                  waddr, raddr;
  logic [pgw_pkg::EntryW-1:0]                 wdata, rdata;
  logic [pgw_pkg::WidxW+pgw_pkg::AddrW-1:0]   widx_ext;
  logic [pgw_pkg::FrameW-1:0]                 rd_frame;
  logic [pgw_pkg::IdxW-1:0]                   rd_idx;
  logic [pgw_pkg::FrameW+pgw_pkg::IdxW-1:0]   walk_word;
  logic [pgw_pkg::FrameW-1:0]                 rdata_frame;

  assign rdata_frame = rdata[pgw_pkg::FrameMsb:pgw_pkg::FrameLsb];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      clr_q <= clr_d;
    end
  end

  assign clr_d = cmd_i.clr_we ? clr_q + pgw_pkg::AddrW'(1) : clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      va_q <= in_va_i;
    end
    if (cmd_i.load) begin
      pa_q   <= pa_d;
      leaf_q <= leaf_d;
      st_q   <= st_d;
    end
  end

  // write port: clearing sweep or an item write (word index wraps)
  assign widx_ext = {{pgw_pkg::AddrW{1'b0}}, in_widx_i};
  assign ram_we   = cmd_i.clr_we | cmd_i.item_we;
  assign waddr    = cmd_i.clr_we ? clr_q : widx_ext[pgw_pkg::AddrW-1:0];
  assign wdata    = cmd_i.clr_we ? '0 : in_data_i;

  // read port: first level from the root and live address, later levels
  // from the entry just read; frame*512+index wraps to the memory size
  always_comb begin
    if (cmd_i.first_rd) begin
      rd_frame = root_q;
      rd_idx   = pgw_pkg::level_index(in_va_i, cmd_i.rd_level);
    end else begin
      rd_frame = rdata_frame;
      rd_idx   = pgw_pkg::level_index(va_q, cmd_i.rd_level);
    end
  end

  assign walk_word = {rd_frame, rd_idx};
  assign raddr     = walk_word[pgw_pkg::AddrW-1:0];
  assign ram_re    = cmd_i.first_rd | cmd_i.step_rd;

  pgw_ram #(
    .Width (pgw_pkg::EntryW),
    .Depth (pgw_pkg::MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    pa_d   = '0;
    leaf_d = '0;
    st_d   = pgw_pkg::StMapped;
    case (cmd_i.res)
      pgw_pkg::RES_WRITE: begin
        st_d = pgw_pkg::StMapped;
      end
      pgw_pkg::RES_NOROOT: begin
        st_d = pgw_pkg::StNoRoot;
      end
      pgw_pkg::RES_ABSENT: begin
        st_d = pgw_pkg::StAbsentL4 + {1'b0, cmd_i.level};
        if (cmd_i.level == pgw_pkg::LastLevel) begin
          leaf_d = rdata;
        end
      end
      pgw_pkg::RES_MAPPED: begin
        pa_d   = {rdata_frame, va_q[pgw_pkg::OffW-1:0]};
        leaf_d = rdata;
      end
      default: begin
        st_d = pgw_pkg::StMapped;
      end
    endcase
  end

  assign sts_o.is_walk   = (in_cmd_i == pgw_pkg::CmdWalk);
  assign sts_o.root_zero = (root_q == '0);
  assign sts_o.present   = rdata[0];
  assign sts_o.clr_last  = &clr_q;

  assign pa_o     = pa_q;
  assign leaf_o   = leaf_q;
  assign status_o = st_q;

endmodule

FILE: src/pgw_ctrl.sv
module pgw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pgw_pkg::dp_sts_t sts_i,
  output pgw_pkg::dp_cmd_t cmd_o
);

  pgw_pkg::state_e            state_q, state_d;
  logic [pgw_pkg::LevelW-1:0] level_q, level_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgw_pkg::S_CLEAR;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output slot free at this edge: empty, or its word leaves now
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    cmd_o    = '0;
    cmd_o.res   = pgw_pkg::RES_WRITE;
    cmd_o.level = level_q;
    in_ready_o  = 1'b0;
    case (state_q)
      pgw_pkg::S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pgw_pkg::S_IDLE;
        end
      end
      pgw_pkg::S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.is_walk) begin
            cmd_o.item_we = 1'b1;
            cmd_o.load    = 1'b1;
            cmd_o.res     = pgw_pkg::RES_WRITE;
          end else if (sts_i.root_zero) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = pgw_pkg::RES_NOROOT;
          end else begin
            cmd_o.first_rd = 1'b1;
            cmd_o.rd_level = '0;
            level_d        = '0;
            state_d        = pgw_pkg::S_WALK;
          end
        end
      end
      pgw_pkg::S_WALK: begin
        if (!sts_i.present) begin
          if (out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = pgw_pkg::RES_ABSENT;
            state_d    = pgw_pkg::S_IDLE;
          end
        end else if (level_q != pgw_pkg::LastLevel) begin
          cmd_o.step_rd  = 1'b1;
          cmd_o.rd_level = level_q + pgw_pkg::LevelW'(1);
          level_d        = level_q + pgw_pkg::LevelW'(1);
        end else if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = pgw_pkg::RES_MAPPED;
          state_d    = pgw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pgw_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && out_valid_q) |-> out_ready_i)
    else $error("result overwritten while waiting");

  // nothing is accepted during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pgw_pkg::S_CLEAR) |-> !cmd_o.accept)
    else $error("item accepted during clear");

  // a started walk begins at the top level
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.first_rd |=> (state_q == pgw_pkg::S_WALK && level_q == '0))
    else $error("walk did not start at top level");

  // a level step always follows a present entry and a read
  a_step_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_rd |-> ($past(cmd_o.first_rd) || $past(cmd_o.step_rd)))
    else $error("level step without preceding read");

endmodule

FILE: src/four_level_page_table_walker.sv
// Channel  Dir  Payload                                         Handshake
// req_i    in   cmd, virtual_address, word_index, entry_data    valid/ready
// rsp_o    out  physical_address, leaf_entry, walk_status       valid/ready
// cfg      in   cfg_wdata_i = root_table_frame                  cfg_we_i, no wait
//
// Walk: accept, then one registered table-memory read per level (the
//   level-to-level loop runs through the single memory read port). Absent
//   entries end the walk early. Write and no-root items load their result at accept.
// Reset: clearing sweep of the table memory, one word a cycle, over all
//   MemWords (4096) words; req_i.ready stays low, cfg writes are taken.
// Stalls: a result word waits in the output register; a new item is taken
//   once the slot frees at that edge; a finishing walk holds until the slot frees.
module four_level_page_table_walker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pgw_pkg::FrameW-1:0] cfg_wdata_i,
  pgw_req_if.sink                    req_i,
  pgw_rsp_if.source                  rsp_o
);

  pgw_pkg::dp_cmd_t dp_cmd;
  pgw_pkg::dp_sts_t dp_sts;

  // sequencer: clear sweep, item accept, level steps, result load
  pgw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // root register, table memory, address formation, output register
  pgw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_cmd_i    (req_i.cmd),
    .in_va_i     (req_i.virtual_address),
    .in_widx_i   (req_i.word_index),
    .in_data_i   (req_i.entry_data),
    .pa_o        (rsp_o.physical_address),
    .leaf_o      (rsp_o.leaf_entry),
    .status_o    (rsp_o.walk_status)
  );

endmodule
